FILE: design/consistent_hash_ring_table_assert.svh
// Assertion macros used by the ring table checker.
`ifndef CONSISTENT_HASH_RING_TABLE_ASSERT_SVH
`define CONSISTENT_HASH_RING_TABLE_ASSERT_SVH

// Clocked on i_clk, off while i_rst_n is low.
`define CHRT_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ring table assertion failed");

// Clocked on i_clk, checked during reset too.
`define CHRT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("ring table assertion failed");

`endif

FILE: design/chrt_pkg.sv
// Types, codes and defaults of the consistent hash ring table.
package chrt_pkg;

    localparam int HASH_W           = 31;
    localparam int MAX_VNODES_DEF   = 256;
    localparam int OWNER_BITS_DEF   = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

FILE: design/chrt_ifs.sv
// Request and response channel interfaces of the ring table.
interface chrt_in_if #(
    parameter int OWNER_BITS = chrt_pkg::OWNER_BITS_DEF
);
    import chrt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [HASH_W-1:0]     hash_value;
    logic [OWNER_BITS-1:0] owner_id;

    modport source (output valid, opcode, hash_value, owner_id, input ready);
    modport sink   (input valid, opcode, hash_value, owner_id, output ready);
endinterface

interface chrt_out_if #(
    parameter int MAX_VNODES = chrt_pkg::MAX_VNODES_DEF,
    parameter int OWNER_BITS = chrt_pkg::OWNER_BITS_DEF
);
    localparam int CW = $clog2(MAX_VNODES + 1);

    logic                  valid;
    logic                  ready;
    logic [OWNER_BITS-1:0] found_owner;
    logic [1:0]            status;
    logic [CW-1:0]         entry_count;

    modport source (output valid, found_owner, status, entry_count, input ready);
    modport sink   (input valid, found_owner, status, entry_count, output ready);
endinterface

FILE: design/chrt_ring_mem.sv
// Entry memory of the ring: one write port, one registered read port.
module chrt_ring_mem #(
    parameter int DEPTH = chrt_pkg::MAX_VNODES_DEF,
    parameter int DW    = chrt_pkg::HASH_W + chrt_pkg::OWNER_BITS_DEF
) (
    input  logic                     i_clk,
    input  chrt_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    output logic [DW-1:0]            o_rd_data
);
    import chrt_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: design/consistent_hash_ring_table.sv
// Insert, remove and lookup walk the stored entries one per cycle through the
// single memory read port. Full insert, empty lookup, empty remove and no-op
// go straight to the result without a walk.
// Throughput: one item at a time; a new word is taken once the previous one is finished.
// Reset (synchronous, active low) empties the ring and drops any pending result;
// memory contents stay undefined and are never read before written.
module consistent_hash_ring_table #(
    parameter int MAX_VNODES = chrt_pkg::MAX_VNODES_DEF,
    parameter int OWNER_BITS = chrt_pkg::OWNER_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    chrt_in_if.sink    i_req,
    chrt_out_if.source o_rsp
);
    import chrt_pkg::*;

    localparam int CW = $clog2(MAX_VNODES + 1);
    localparam int AW = $clog2(MAX_VNODES);
    localparam int DW = HASH_W + OWNER_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VNODES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PLACE,
        S_DONE
    } t_state;

    t_state                r_state;
    t_op                   r_op;
    logic [HASH_W-1:0]     r_hash;
    logic [OWNER_BITS-1:0] r_owner;
    logic [CW-1:0]         r_count;
    logic                  r_issue;
    logic [CW-1:0]         r_raddr;
    logic                  r_dv;
    logic [CW-1:0]         r_didx;
    logic [CW-1:0]         r_wr;
    logic [OWNER_BITS-1:0] r_first;
    logic [OWNER_BITS-1:0] r_res_owner;
    logic [1:0]            r_res_status;
    logic                  r_out_vld;
    logic [OWNER_BITS-1:0] r_out_owner;
    logic [1:0]            r_out_status;
    logic [CW-1:0]         r_out_count;

    t_mem_ctl              mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic [DW-1:0]         rd_data;
    logic [HASH_W-1:0]     rd_hash;
    logic [OWNER_BITS-1:0] rd_own;
    logic                  issue;
    logic                  keep;
    logic [CW-1:0]         last_idx;
    logic [CW-1:0]         didx_next;
    t_op                   in_op;

    assign in_op     = t_op'(i_req.opcode);
    assign issue     = (r_state == S_RUN) && r_issue;
    assign rd_hash   = rd_data[DW-1:OWNER_BITS];
    assign rd_own    = rd_data[OWNER_BITS-1:0];
    assign keep      = rd_own != r_owner;
    assign last_idx  = r_count - CW'(1);
    assign didx_next = r_didx + CW'(1);

    always_comb begin
        mem_ctl.rd_en = issue;
        mem_ctl.wr_en = 1'b0;
        wr_addr       = didx_next[AW-1:0];
        wr_data       = rd_data;
        if (r_state == S_RUN && r_dv) begin
            case (r_op)
                OP_INSERT: begin
                    mem_ctl.wr_en = rd_hash > r_hash;
                end
                OP_REMOVE: begin
                    mem_ctl.wr_en = keep;
                    wr_addr       = r_wr[AW-1:0];
                end
                default: begin
                    mem_ctl.wr_en = 1'b0;
                end
            endcase
        end else if (r_state == S_PLACE) begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = r_wr[AW-1:0];
            wr_data       = {r_hash, r_owner};
        end
    end

    chrt_ring_mem #(
        .DEPTH (MAX_VNODES),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (r_raddr[AW-1:0]),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_issue   <= 1'b0;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_dv <= issue;
            if (issue) begin
                r_didx <= r_raddr;
                if (r_op == OP_INSERT) begin
                    if (r_raddr == '0) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_raddr <= r_raddr - CW'(1);
                    end
                end else begin
                    if (r_raddr == last_idx) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_raddr <= r_raddr + CW'(1);
                    end
                end
            end
            if (r_out_vld && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op         <= in_op;
                        r_hash       <= i_req.hash_value;
                        r_owner      <= i_req.owner_id;
                        r_wr         <= '0;
                        r_raddr      <= '0;
                        r_res_owner  <= '0;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                        case (in_op)
                            OP_INSERT: begin
                                if (r_count == MAX_CNT) begin
                                    r_res_status <= ST_FULL;
                                end else if (r_count == '0) begin
                                    r_state <= S_PLACE;
                                end else begin
                                    r_raddr <= last_idx;
                                    r_issue <= 1'b1;
                                    r_state <= S_RUN;
                                end
                            end
                            OP_REMOVE: begin
                                if (r_count != '0) begin
                                    r_issue <= 1'b1;
                                    r_state <= S_RUN;
                                end
                            end
                            OP_LOOKUP: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_EMPTY;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= S_RUN;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_dv) begin
                        case (r_op)
                            OP_INSERT: begin
                                if (rd_hash <= r_hash) begin
                                    r_wr    <= didx_next;
                                    r_issue <= 1'b0;
                                    r_state <= S_PLACE;
                                end else if (r_didx == '0) begin
                                    r_wr    <= '0;
                                    r_issue <= 1'b0;
                                    r_state <= S_PLACE;
                                end
                            end
                            OP_REMOVE: begin
                                if (keep) begin
                                    r_wr <= r_wr + CW'(1);
                                end
                                if (r_didx == last_idx) begin
                                    r_count <= r_wr + CW'(keep);
                                    r_issue <= 1'b0;
                                    r_state <= S_DONE;
                                end
                            end
                            OP_LOOKUP: begin
                                if (r_didx == '0) begin
                                    r_first <= rd_own;
                                end
                                if (rd_hash > r_hash) begin
                                    r_res_owner <= rd_own;
                                    r_issue     <= 1'b0;
                                    r_state     <= S_DONE;
                                end else if (r_didx == last_idx) begin
                                    r_res_owner <= (r_didx == '0) ? rd_own : r_first;
                                    r_issue     <= 1'b0;
                                    r_state     <= S_DONE;
                                end
                            end
                            default: begin
                                r_issue <= 1'b0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PLACE: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_owner  <= r_res_owner;
                        r_out_status <= r_res_status;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = r_state == S_IDLE;
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.found_owner = r_out_owner;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;
endmodule

FILE: design/chrt_check.sv
// Port-level checker of the ring table, bound to the top level.
`include "consistent_hash_ring_table_assert.svh"

module chrt_check #(
    parameter int MAX_VNODES = chrt_pkg::MAX_VNODES_DEF,
    parameter int OWNER_BITS = chrt_pkg::OWNER_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [OWNER_BITS-1:0]              i_found_owner,
    input logic [1:0]                         i_status,
    input logic [$clog2(MAX_VNODES + 1)-1:0]  i_entry_count
);
    import chrt_pkg::*;

    localparam int CW = $clog2(MAX_VNODES + 1);

    `CHRT_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    `CHRT_ASSERT(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready)
    `CHRT_ASSERT(a_count_range, i_out_valid |-> i_entry_count <= CW'(MAX_VNODES))
    `CHRT_ASSERT(a_full_count, i_out_valid && i_status == ST_FULL |-> i_entry_count == CW'(MAX_VNODES) && i_found_owner == '0)
    `CHRT_ASSERT_ALWAYS(a_empty_count, i_out_valid && i_status == ST_EMPTY |-> i_entry_count == '0 && i_found_owner == '0)
endmodule

bind consistent_hash_ring_table chrt_check #(
    .MAX_VNODES (MAX_VNODES),
    .OWNER_BITS (OWNER_BITS)
) u_chrt_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_found_owner (o_rsp.found_owner),
    .i_status      (o_rsp.status),
    .i_entry_count (o_rsp.entry_count)
);

FILE: tb/tb.sv
// Self-checking testbench for the consistent hash ring table: random and directed requests.
`timescale 1ns / 1ps

module tb;
    import chrt_pkg::*;

    localparam int RING_DEPTH   = MAX_VNODES_DEF;
    localparam int LIMIT_CYCLES = 3_000_000;

    typedef struct {
        bit   [7:0] owner;
        logic [1:0] status;
        bit   [8:0] count;
    } t_ring_answer;

    class ring_table_model;
        bit [HASH_W-1:0] hashes [RING_DEPTH];
        bit [7:0]        owners [RING_DEPTH];
        int unsigned     count = 0;
        t_ring_answer    expected_answers [$];
        int errors   = 0;
        int n_insert = 0;
        int n_full   = 0;
        int n_remove = 0;
        int n_lookup = 0;
        int n_empty  = 0;
        int n_nop    = 0;
        int n_words  = 0;
        int peak     = 0;

        function void accept_request(t_op op, bit [HASH_W-1:0] h, bit [7:0] o);
            t_ring_answer a;
            int unsigned pos;
            int unsigned i;
            int unsigned wr;
            a.owner  = '0;
            a.status = ST_OK;
            n_words++;
            case (op)
                OP_INSERT: begin
                    n_insert++;
                    if (count >= RING_DEPTH) begin
                        a.status = ST_FULL;
                        n_full++;
                    end else begin
                        pos = 0;
                        while (pos < count && hashes[pos] <= h) pos++;
                        for (i = count; i > pos; i--) begin
                            hashes[i] = hashes[i-1];
                            owners[i] = owners[i-1];
                        end
                        hashes[pos] = h;
                        owners[pos] = o;
                        count++;
                        if (int'(count) > peak) peak = int'(count);
                    end
                end
                OP_REMOVE: begin
                    n_remove++;
                    wr = 0;
                    for (i = 0; i < count; i++) begin
                        if (owners[i] != o) begin
                            hashes[wr] = hashes[i];
                            owners[wr] = owners[i];
                            wr++;
                        end
                    end
                    count = wr;
                end
                OP_LOOKUP: begin
                    n_lookup++;
                    if (count == 0) begin
                        a.status = ST_EMPTY;
                        n_empty++;
                    end else begin
                        pos = 0;
                        while (pos < count && hashes[pos] <= h) pos++;
                        if (pos >= count) pos = 0;
                        a.owner = owners[pos];
                    end
                end
                default: begin
                    n_nop++;
                end
            endcase
            a.count = 9'(count);
            expected_answers.insert(expected_answers.size(), a);
        endfunction

        function void check_response(logic [7:0] found, logic [1:0] status, logic [8:0] cnt);
            t_ring_answer a;
            if (expected_answers.size() == 0) begin
                $error("response word with no request pending");
                errors++;
                return;
            end
            a = expected_answers.pop_front();
            if (found !== a.owner) begin
                $error("found_owner mismatch: expected %0d, got %0d", a.owner, found);
                errors++;
            end
            if (status !== a.status) begin
                $error("status mismatch: expected %0d, got %0d", a.status, status);
                errors++;
            end
            if (cnt !== a.count) begin
                $error("entry_count mismatch: expected %0d, got %0d", a.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    chrt_in_if  req_if ();
    chrt_out_if rsp_if ();

    consistent_hash_ring_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ring_table_model ring;
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int stall_left      = 0;
    int cycles          = 0;

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic bit [HASH_W-1:0] pick_hash();
        int unsigned r;
        bit [HASH_W-1:0] h;
        r = $urandom_range(0, 99);
        h = HASH_W'($urandom);
        if (r < 8) begin
            h = '0;
        end else if (r < 16) begin
            h = '1;
        end else if (r < 55 && ring.count > 0) begin
            h = ring.hashes[$urandom_range(0, ring.count - 1)];
            if (r < 30) begin
                h = h + 1'b1;
            end else if (r < 40) begin
                h = h - 1'b1;
            end
        end
        return h;
    endfunction

    function automatic bit [7:0] pick_owner();
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_req(input t_op op, input bit [HASH_W-1:0] h, input bit [7:0] o);
        int gap;
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.hash_value <= h;
        req_if.owner_id   <= o;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        ring.accept_request(op, h, o);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_removal();
        bit [7:0] o;
        if (ring.count > 0 && $urandom_range(0, 2) != 0) begin
            o = ring.owners[$urandom_range(0, ring.count - 1)];
        end else begin
            o = pick_owner();
        end
        send_req(OP_REMOVE, HASH_W'($urandom), o);
    endtask

    task automatic run_mixed(input int n);
        int unsigned r;
        int unsigned ins_w;
        int unsigned rem_w;
        for (int k = 0; k < n; k++) begin
            if (k % 100 == 0) begin
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            ins_w = (ring.count > 48) ? 12 : 30;
            rem_w = (ring.count > 48) ? 30 : 10;
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                send_req(OP_INSERT, pick_hash(), pick_owner());
            end else if (r < ins_w + rem_w) begin
                send_removal();
            end else if (r < 93) begin
                send_req(OP_LOOKUP, pick_hash(), pick_owner());
            end else begin
                send_req(OP_NOP, HASH_W'($urandom), pick_owner());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!receiver_stalls) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left   <= pick_gap();
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            ring.check_response(rsp_if.found_owner, rsp_if.status, rsp_if.entry_count);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.opcode     = OP_NOP;
        req_if.hash_value = '0;
        req_if.owner_id   = '0;
        rsp_if.ready      = 1'b0;
        ring = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(OP_LOOKUP, '0, 8'd0);
        send_req(OP_REMOVE, '1, 8'd5);
        send_req(OP_NOP, '1, 8'd255);
        send_req(OP_INSERT, 31'd100, 8'd1);
        send_req(OP_INSERT, '0, 8'd0);
        send_req(OP_INSERT, '1, 8'd255);
        send_req(OP_INSERT, 31'd100, 8'd2);
        send_req(OP_LOOKUP, '0, 8'd0);
        send_req(OP_LOOKUP, 31'd99, 8'd0);
        send_req(OP_LOOKUP, 31'd100, 8'd0);
        send_req(OP_LOOKUP, '1, 8'd0);
        send_req(OP_LOOKUP, 31'h7FFF_FFFE, 8'd0);
        send_req(OP_REMOVE, '0, 8'd7);
        send_req(OP_REMOVE, '0, 8'd255);
        send_req(OP_LOOKUP, 31'd100, 8'd255);
        send_req(OP_NOP, '0, 8'd0);
        send_req(OP_INSERT, 31'd50, 8'd255);
        send_req(OP_REMOVE, '0, 8'd1);
        send_req(OP_REMOVE, '0, 8'd0);
        send_req(OP_REMOVE, '0, 8'd2);
        send_req(OP_LOOKUP, '1, 8'd0);
        send_req(OP_REMOVE, '0, 8'd255);
        send_req(OP_LOOKUP, 31'd50, 8'd0);

        run_mixed(350);

        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        while (ring.count < RING_DEPTH) begin
            if ($urandom_range(0, 4) == 0) begin
                send_req(OP_LOOKUP, pick_hash(), pick_owner());
            end else begin
                send_req(OP_INSERT, pick_hash(), pick_owner());
            end
        end
        repeat (3) send_req(OP_INSERT, pick_hash(), pick_owner());
        send_req(OP_LOOKUP, '1, 8'd0);
        send_req(OP_NOP, HASH_W'($urandom), 8'd0);
        repeat (4) send_req(OP_LOOKUP, pick_hash(), pick_owner());
        while (ring.count > 4) begin
            send_req(OP_REMOVE, HASH_W'($urandom),
                     ring.owners[$urandom_range(0, ring.count - 1)]);
            repeat ($urandom_range(1, 3)) send_req(OP_LOOKUP, pick_hash(), pick_owner());
        end

        run_mixed(400);
        req_if.valid <= 1'b0;

        while (ring.expected_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d words: %0d inserts (%0d on a full ring), %0d removes,",
                 ring.n_words, ring.n_insert, ring.n_full, ring.n_remove);
        $display("  %0d lookups (%0d on an empty ring), %0d no-ops; ring peaked at %0d entries",
                 ring.n_lookup, ring.n_empty, ring.n_nop, ring.peak);
        if (ring.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/chrt_pkg.sv
design/chrt_ifs.sv
design/chrt_ring_mem.sv
design/consistent_hash_ring_table.sv
design/chrt_check.sv
tb/tb.sv
